[rtl/core/segment_fit_allocator_macros.svh]
// Assertion helpers for the segment fit allocator.
// Both expect clk_i and rst_ni in scope.
`ifndef SEGMENT_FIT_ALLOCATOR_MACROS_SVH
`define SEGMENT_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define SFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sfa_pkg.sv]
`default_nettype none

package sfa_pkg;

  localparam int KIND_W   = 2;
  localparam int REQ_W    = 21;
  localparam int ADDR_W   = 20;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int NEED_W   = 22;  // aligned request, up to 2^21
  localparam int CFG_W    = 21;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA  = 1'b1;

endpackage

`default_nettype wire

[rtl/core/sfa_ram.sv]
`default_nettype none

// Simple dual-port RAM, registered read.
module sfa_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/segment_fit_allocator.sv]
// Segment fit allocator: address-ordered table of arena segments.
// Input channel (in_valid_i/in_ready_o) takes one item: kind_i selects
// allocate, free or restart; request_size_i and address_i are its operands.
// Output channel (out_valid_o/out_ready_i) returns one item per input item:
// status, granted offset and the segment count after the item.
// Config port: cfg_we_i writes policy (index 0) or arena_bytes (index 1);
// arena_bytes takes effect on the next restart item.
// Flow: a scan reads one table entry a cycle (first and next fit may stop
// early), then a decide state follows; a free then returns its result, an
// allocate without split marks the chosen entry first. A split moves the
// entries above the chosen entry up by one, top first, and writes the new
// free segment before the mark. Restart and unused kinds go to the result.
// Scan and split speed is set by the single read and single write port of
// the table memory: one entry read and one written per cycle.
// One item is worked on at a time. A new item is taken while a finished
// result still waits on the output register; a stalled receiver then holds
// the block in its result state until the register drains.
// Reset: async, active low. The first cycle after reset writes entry zero
// as one free segment covering the arena; no item is taken until then.
`default_nettype none

module segment_fit_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int OFFSET_BITS  = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sfa_pkg::KIND_W-1:0]    kind_i,
  input  logic [sfa_pkg::REQ_W-1:0]     request_size_i,
  input  logic [sfa_pkg::ADDR_W-1:0]    address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sfa_pkg::STATUS_W-1:0]  status_o,
  output logic [sfa_pkg::ADDR_W-1:0]    granted_offset_o,
  output logic [sfa_pkg::COUNT_W-1:0]   segment_count_o
);
  import sfa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int SIZE_W = OFFSET_BITS + 1;
  localparam int CMP_W  = (SIZE_W > NEED_W) ? SIZE_W : NEED_W;
  // table entry: {used, size, start}
  localparam int ENT_W  = 1 + SIZE_W + OFFSET_BITS;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_SPLIT, S_MARK, S_RESP
  } state_e;

  state_e state_q, state_d;

  logic [1:0]             policy_q, policy_d;
  logic [CFG_W-1:0]       arena_q, arena_d;
  logic [KIND_W-1:0]      kind_q, kind_d;
  logic [NEED_W-1:0]      need_q, need_d;
  logic [OFFSET_BITS-1:0] addr_q, addr_d;
  logic [IDX_W-1:0]       rd_pos_q, rd_pos_d;
  logic [CNT_W-1:0]       rd_cnt_q, rd_cnt_d;
  logic                   rv_q, rv_d;
  logic [IDX_W-1:0]       rv_idx_q, rv_idx_d;
  logic                   hit_q, hit_d;
  logic [IDX_W-1:0]       hit_idx_q, hit_idx_d;
  logic [OFFSET_BITS-1:0] hit_start_q, hit_start_d;
  logic [SIZE_W-1:0]      hit_size_q, hit_size_d;
  logic                   found_q, found_d;
  logic                   twice_q, twice_d;
  logic [CNT_W-1:0]       total_q, total_d;
  logic [IDX_W-1:0]       resume_q, resume_d;
  logic [CNT_W-1:0]       sh_q, sh_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [ADDR_W-1:0]      res_granted_q, res_granted_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [ADDR_W-1:0]      granted_q, granted_d;
  logic [COUNT_W-1:0]     count_q, count_d;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [ENT_W-1:0]       ram_wdata, ram_rdata;

  logic                   r_used;
  logic [SIZE_W-1:0]      r_size;
  logic [OFFSET_BITS-1:0] r_start;
  logic                   r_fit;
  logic [NEED_W-1:0]      arena_min, arena_al;
  logic [CMP_W-1:0]       arena_cap;
  logic [SIZE_W-1:0]      arena_size;
  logic [SIZE_W-1:0]      rest;
  logic [OFFSET_BITS-1:0] split_start;

  sfa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign r_used  = ram_rdata[ENT_W-1];
  assign r_size  = ram_rdata[OFFSET_BITS +: SIZE_W];
  assign r_start = ram_rdata[OFFSET_BITS-1:0];
  assign r_fit   = !r_used && (CMP_W'(r_size) >= CMP_W'(need_q));

  // Arena size for a rebuild: at least 4, rounded up to 4, capped at 2^OFFSET_BITS.
  always_comb begin
    arena_min  = (NEED_W'(arena_q) < NEED_W'(4)) ? NEED_W'(4) : NEED_W'(arena_q);
    arena_al   = (arena_min + NEED_W'(3)) & ~NEED_W'(3);
    arena_cap  = CMP_W'(1) << OFFSET_BITS;
    arena_size = (CMP_W'(arena_al) > arena_cap) ? SIZE_W'(arena_cap) : SIZE_W'(arena_al);
  end

  assign rest        = hit_size_q - SIZE_W'(need_q);
  assign split_start = OFFSET_BITS'(CMP_W'(hit_start_q) + CMP_W'(need_q));

  always_comb begin
    state_d       = state_q;
    policy_d      = policy_q;
    arena_d       = arena_q;
    kind_d        = kind_q;
    need_d        = need_q;
    addr_d        = addr_q;
    rd_pos_d      = rd_pos_q;
    rd_cnt_d      = rd_cnt_q;
    rv_d          = rv_q;
    rv_idx_d      = rv_idx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    hit_start_d   = hit_start_q;
    hit_size_d    = hit_size_q;
    found_d       = found_q;
    twice_d       = twice_q;
    total_d       = total_q;
    resume_d      = resume_q;
    sh_d          = sh_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    status_d      = status_q;
    granted_d     = granted_q;
    count_d       = count_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = rd_pos_q;
    in_ready_o    = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POLICY: policy_d = cfg_data_i[1:0];
        CFG_ARENA:  arena_d  = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, arena_size, OFFSET_BITS'(0)};
        total_d   = CNT_W'(1);
        resume_d  = '0;
        state_d   = S_IDLE;
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d        = kind_i;
          need_d        = (NEED_W'(request_size_i) + NEED_W'(3)) & ~NEED_W'(3);
          addr_d        = OFFSET_BITS'(address_i);
          rd_pos_d      = (policy_q == POL_NEXT && CNT_W'(resume_q) < total_q)
                          ? resume_q : '0;
          rd_cnt_d      = '0;
          rv_d          = 1'b0;
          hit_d         = 1'b0;
          found_d       = 1'b0;
          twice_d       = 1'b0;
          res_status_d  = ST_OK;
          res_granted_d = '0;
          case (kind_i)
            KIND_ALLOC, KIND_FREE: state_d = S_SCAN;
            KIND_RESTART: begin
              ram_we    = 1'b1;
              ram_wdata = {1'b0, arena_size, OFFSET_BITS'(0)};
              total_d   = CNT_W'(1);
              resume_d  = '0;
              state_d   = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle, in scan order
        if (rd_cnt_q < total_q) begin
          ram_raddr = rd_pos_q;
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
          rd_pos_d  = ((CNT_W'(rd_pos_q) + CNT_W'(1)) < total_q)
                      ? rd_pos_q + IDX_W'(1) : '0;
          rv_d      = 1'b1;
          rv_idx_d  = rd_pos_q;
        end else begin
          rv_d = 1'b0;
        end
        if (rd_cnt_q == total_q && !rv_q) begin
          state_d = S_DECIDE;
        end
        // look at the entry read last cycle
        if (rv_q) begin
          if (kind_q == KIND_ALLOC) begin
            if (r_fit) begin
              if (policy_q == POL_FIRST || policy_q == POL_NEXT) begin
                hit_d       = 1'b1;
                hit_idx_d   = rv_idx_q;
                hit_start_d = r_start;
                hit_size_d  = r_size;
                state_d     = S_DECIDE;
              end else if (!hit_q ||
                           (policy_q == POL_BEST && r_size < hit_size_q) ||
                           (policy_q == POL_WORST && r_size > hit_size_q)) begin
                hit_d       = 1'b1;
                hit_idx_d   = rv_idx_q;
                hit_start_d = r_start;
                hit_size_d  = r_size;
              end
            end
          end else if (r_start == addr_q) begin
            found_d   = 1'b1;
            twice_d   = twice_d || !r_used;
            ram_we    = 1'b1;
            ram_waddr = rv_idx_q;
            ram_wdata = {1'b0, r_size, r_start};
          end
        end
      end

      S_DECIDE: begin
        rv_d    = 1'b0;
        state_d = S_RESP;
        if (kind_q == KIND_ALLOC) begin
          if (!hit_q) begin
            res_status_d = ST_NOFIT;
          end else if (rest != '0) begin
            if (total_q >= CNT_W'(MAX_SEGMENTS)) begin
              res_status_d = ST_FULL;
            end else begin
              sh_d    = total_q - CNT_W'(1);
              state_d = S_SHIFT;
            end
          end else begin
            state_d = S_MARK;
          end
        end else begin
          res_status_d = !found_q ? ST_UNKNOWN : (twice_q ? ST_DOUBLE : ST_OK);
        end
      end

      S_SHIFT: begin
        // move entries above the chosen one up by one, top first
        if (sh_q > CNT_W'(hit_idx_q)) begin
          ram_raddr = sh_q[IDX_W-1:0];
          sh_d      = sh_q - CNT_W'(1);
          rv_d      = 1'b1;
          rv_idx_d  = sh_q[IDX_W-1:0];
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = rv_idx_q + IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (!(sh_q > CNT_W'(hit_idx_q)) && !rv_q) begin
          state_d = S_SPLIT;
        end
      end

      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx_q + IDX_W'(1);
        ram_wdata = {1'b0, rest, split_start};
        total_d   = total_q + CNT_W'(1);
        state_d   = S_MARK;
      end

      S_MARK: begin
        ram_we        = 1'b1;
        ram_waddr     = hit_idx_q;
        ram_wdata     = {1'b1, SIZE_W'(need_q), hit_start_q};
        resume_d      = hit_idx_q;
        res_status_d  = ST_OK;
        res_granted_d = ADDR_W'(hit_start_q);
        state_d       = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          granted_d   = res_granted_q;
          count_d     = COUNT_W'(total_q);
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      policy_q    <= POL_FIRST;
      arena_q     <= CFG_W'(65536);
      total_q     <= CNT_W'(1);
      resume_q    <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      arena_q     <= arena_d;
      total_q     <= total_d;
      resume_q    <= resume_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    need_q        <= need_d;
    addr_q        <= addr_d;
    rd_pos_q      <= rd_pos_d;
    rd_cnt_q      <= rd_cnt_d;
    rv_idx_q      <= rv_idx_d;
    hit_q         <= hit_d;
    hit_idx_q     <= hit_idx_d;
    hit_start_q   <= hit_start_d;
    hit_size_q    <= hit_size_d;
    found_q       <= found_d;
    twice_q       <= twice_d;
    sh_q          <= sh_d;
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    status_q      <= status_d;
    granted_q     <= granted_d;
    count_q       <= count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_offset_o = granted_q;
  assign segment_count_o  = count_q;

endmodule

`default_nettype wire

[rtl/core/sfa_checker.sv]
`default_nettype none
`include "segment_fit_allocator_macros.svh"

module sfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sfa_pkg::STATUS_W-1:0]  status_o,
  input logic [sfa_pkg::ADDR_W-1:0]    granted_offset_o,
  input logic [sfa_pkg::COUNT_W-1:0]   segment_count_o
);
  import sfa_pkg::*;

  logic                                    out_stall;
  logic                                    res_fail;
  logic                                    in_acc;
  logic [STATUS_W+ADDR_W+COUNT_W-1:0]      res_bus;

  assign out_stall = out_valid_o && !out_ready_i;
  assign res_fail  = out_valid_o && (status_o != ST_OK);
  assign in_acc    = in_valid_i && in_ready_o;
  assign res_bus   = {status_o, granted_offset_o, segment_count_o};

  `SFA_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(res_bus), "stalled result changed")
  `SFA_ASSERT_NOW(a_status_range, out_valid_o, status_o <= ST_UNKNOWN, "bad status code")
  `SFA_ASSERT_NOW(a_fail_no_offset, res_fail, granted_offset_o == '0, "offset on failed item")
  `SFA_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready_o, "item taken while busy")

endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (.*);

`default_nettype wire

[dv/segment_fit_allocator_test.sv]
// Self-checking bench for the segment fit allocator.
// A directed table covers reset, extremes, every kind, every status but
// table-full, and zero-size and double-free; a fill of the table to its
// limit brings table-full. Random traffic follows, mostly alloc/free mixes
// under every policy, with restarts and small arenas so no-fit comes up often.
`default_nettype none

module segment_fit_allocator_test;
  import sfa_pkg::*;

  localparam int NSEG      = 64;
  localparam int ABITS     = 20;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i = '0;
  logic [REQ_W-1:0]     request_size_i = '0;
  logic [ADDR_W-1:0]    address_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [ADDR_W-1:0]    granted_offset_o;
  logic [COUNT_W-1:0]   segment_count_o;

  always #10 clk_i = ~clk_i;

  segment_fit_allocator dut (.*);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   offset;
    logic [COUNT_W-1:0]  count;
  } alloc_result_t;

  // Shadow copy of the segment table and registers.
  logic [ABITS:0]   seg_base [NSEG];
  logic [ABITS+1:0] seg_len  [NSEG];
  bit               seg_busy [NSEG];
  int               seg_cnt;
  int               last_grant;
  policy_e          cur_policy;
  logic [CFG_W-1:0] cur_arena;

  alloc_result_t pending_q[$];
  int  fail_cnt = 0;
  int  result_cnt = 0;
  int  idle_cycles = 0;
  int  status_seen [5];
  bit  stall_rx = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_cnt++;
  endtask

  function automatic void rebuild_arena();
    logic [ABITS+2:0] a;
    a = cur_arena;
    if (a < 4) a = 4;
    a = (a + 3) & ~23'd3;
    if (a > (1 << ABITS)) a = 1 << ABITS;
    for (int i = 0; i < NSEG; i++) begin
      seg_base[i] = '0;
      seg_len[i]  = '0;
      seg_busy[i] = 1'b0;
    end
    seg_len[0] = a;
    seg_cnt    = 1;
    last_grant = 0;
  endfunction

  function automatic bit seg_fits(int i, logic [ABITS+2:0] need);
    return !seg_busy[i] && seg_len[i] >= need;
  endfunction

  function automatic int choose_segment(logic [ABITS+2:0] need);
    int best;
    int pos;
    best = seg_cnt;
    if (cur_policy == POL_NEXT) begin
      pos = (last_grant < seg_cnt) ? last_grant : 0;
      for (int i = 0; i < seg_cnt; i++) begin
        if (seg_fits(pos, need)) return pos;
        pos = (pos + 1 < seg_cnt) ? pos + 1 : 0;
      end
      return seg_cnt;
    end
    for (int i = 0; i < seg_cnt; i++) begin
      if (!seg_fits(i, need)) continue;
      if (cur_policy == POL_FIRST) return i;
      if (best == seg_cnt ||
          (cur_policy == POL_BEST  && seg_len[i] < seg_len[best]) ||
          (cur_policy == POL_WORST && seg_len[i] > seg_len[best]))
        best = i;
    end
    return best;
  endfunction

  // Applies one item to the shadow table and returns its result.
  function automatic alloc_result_t apply_item(logic [KIND_W-1:0] k,
                                               logic [REQ_W-1:0] req,
                                               logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    logic [ABITS+2:0] need;
    logic [ABITS+2:0] rest;
    int idx;
    bit hit;
    bit twice;
    r = '0;
    r.status = ST_OK;
    if (k == KIND_ALLOC) begin
      need = (req + 3) & ~23'd3;
      idx  = choose_segment(need);
      if (idx >= seg_cnt) begin
        r.status = ST_NOFIT;
      end else begin
        rest = seg_len[idx] - need;
        if (rest > 0 && seg_cnt >= NSEG) begin
          r.status = ST_FULL;
        end else begin
          if (rest > 0) begin
            for (int j = seg_cnt; j > idx + 1; j--) begin
              seg_base[j] = seg_base[j-1];
              seg_len[j]  = seg_len[j-1];
              seg_busy[j] = seg_busy[j-1];
            end
            seg_base[idx+1] = (seg_base[idx] + need) & ((1 << ABITS) - 1);
            seg_len[idx+1]  = rest;
            seg_busy[idx+1] = 1'b0;
            seg_cnt++;
          end
          seg_busy[idx] = 1'b1;
          seg_len[idx]  = need;
          last_grant    = idx;
          r.offset      = seg_base[idx][ABITS-1:0];
        end
      end
    end else if (k == KIND_FREE) begin
      hit = 0;
      twice = 0;
      for (int i = 0; i < seg_cnt; i++) begin
        if (seg_base[i] == addr) begin
          hit = 1;
          if (!seg_busy[i]) twice = 1;
          seg_busy[i] = 1'b0;
        end
      end
      r.status = !hit ? ST_UNKNOWN : (twice ? ST_DOUBLE : ST_OK);
    end else if (k == KIND_RESTART) begin
      rebuild_arena();
    end
    r.count = seg_cnt;
    return r;
  endfunction

  // Random gap: mostly zero or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [REQ_W-1:0] req,
                           input logic [ADDR_W-1:0] addr, input bit check_now,
                           input alloc_result_t typed);
    alloc_result_t r;
    r = apply_item(k, req, addr);
    if (check_now && r != typed) begin
      report_mismatch("directed row vs predictor", int'(r), int'(typed));
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    request_size_i <= req;
    address_i      <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(r);
    in_valid_i <= 1'b0;
    // the block is busy in the cycle after it takes an item
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_POLICY) cur_policy = policy_e'(val[1:0]);
    else cur_arena = val;
  endtask

  // Receiver with random stalls; compares each item with the oldest prediction.
  always @(posedge clk_i) begin
    alloc_result_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          w = pending_q.pop_front();
          if (status_o != w.status) report_mismatch("status", status_o, w.status);
          if (granted_offset_o != w.offset)
            report_mismatch("granted_offset", granted_offset_o, w.offset);
          if (segment_count_o != w.count)
            report_mismatch("segment_count", segment_count_o, w.count);
          if (w.status <= ST_UNKNOWN) status_seen[w.status]++;
        end
      end
      out_ready_i <= stall_rx ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_rx <= ~stall_rx;
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("watchdog expired");
      $display("[segment_fit_allocator] ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [KIND_W-1:0] k;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    alloc_result_t     res;
  } stim_row_t;

  stim_row_t rows[$];
  logic [ADDR_W-1:0] granted[$];

  initial begin
    alloc_result_t r;
    int k;
    int n;
    cur_policy = POL_FIRST;
    cur_arena = 65536;
    rebuild_arena();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at reset settings; typed rows are obvious by inspection.
    rows = '{
      '{KIND_ALLOC,   21'd5,      20'd0, 1, '{ST_OK, 20'd0, 7'd2}},
      '{KIND_ALLOC,   21'd0,      20'd0, 1, '{ST_OK, 20'd8, 7'd3}},
      '{KIND_ALLOC,   21'h1FFFFF, 20'd0, 1, '{ST_NOFIT, 20'd0, 7'd3}},
      '{KIND_FREE,    21'd0,      20'd4, 1, '{ST_UNKNOWN, 20'd0, 7'd3}},
      '{KIND_FREE,    21'd0,      20'd8, 1, '{ST_DOUBLE, 20'd0, 7'd3}},
      '{KIND_FREE,    21'd0,      20'd0, 1, '{ST_OK, 20'd0, 7'd3}},
      '{KIND_FREE,    21'd0,      20'd0, 1, '{ST_DOUBLE, 20'd0, 7'd3}},
      '{KIND_FREE,    21'h1FFFFF, 20'hFFFFF, 1, '{ST_UNKNOWN, 20'd0, 7'd3}},
      '{2'd3,         21'h1FFFFF, 20'hFFFFF, 1, '{ST_OK, 20'd0, 7'd3}},
      '{KIND_ALLOC,   21'd65535,  20'd0, 0, '{ST_OK, 20'd0, 7'd0}},
      '{KIND_RESTART, 21'd0,      20'd0, 1, '{ST_OK, 20'd0, 7'd1}},
      '{KIND_ALLOC,   21'd65536,  20'd0, 1, '{ST_OK, 20'd0, 7'd1}},
      '{KIND_ALLOC,   21'd1,      20'd0, 1, '{ST_NOFIT, 20'd0, 7'd1}},
      '{KIND_RESTART, 21'd0,      20'd0, 1, '{ST_OK, 20'd0, 7'd1}}
    };
    foreach (rows[i]) send_item(rows[i].k, rows[i].req, rows[i].addr, rows[i].typed,
                                rows[i].res);
    wait_drained();

    // Largest arena: fill the table to its limit with tiny grants.
    write_reg(CFG_ARENA, 21'h1FFFFF);
    send_item(KIND_RESTART, '0, '0, 0, r);
    for (int i = 0; i < NSEG + 1; i++) send_item(KIND_ALLOC, 21'd4, '0, 0, r);
    wait_drained();

    // Random phases across policies and arena sizes, extremes included.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_POLICY, ph % 4);
      case (ph % 3)
        0: write_reg(CFG_ARENA, $urandom_range(0, 3));
        1: write_reg(CFG_ARENA, $urandom_range(64, 4096));
        default: write_reg(CFG_ARENA, $urandom_range(0, 21'h1FFFFF));
      endcase
      send_item(KIND_RESTART, '0, '0, 0, r);
      granted.delete();
      for (int i = 0; i < 40; i++) begin
        repeat (gap_len()) @(posedge clk_i);
        k = $urandom_range(0, 99);
        if (k < 55) begin
          n = $urandom_range(0, 9);
          send_item(KIND_ALLOC, n == 0 ? $urandom_range(0, 21'h1FFFFF) :
                    (n < 3 ? $urandom_range(0, 8) : $urandom_range(1, cur_arena / 8 + 4)),
                    $urandom, 0, r);
          if (pending_q.size() && pending_q[$].status == ST_OK)
            granted.push_back(pending_q[$].offset);
        end else if (k < 90 && granted.size()) begin
          n = $urandom_range(0, granted.size() - 1);
          send_item(KIND_FREE, $urandom, granted[n], 0, r);
          if ($urandom_range(0, 2) != 0) granted.delete(n);
        end else if (k < 96) begin
          send_item(KIND_FREE, $urandom, $urandom, 0, r);
        end else begin
          send_item($urandom_range(2, 3), $urandom, $urandom, 0, r);
        end
      end
      // Let the sender hold off until the block has drained once.
      if (ph == 5) while (pending_q.size() != 0) @(posedge clk_i);
      wait_drained();
    end

    $display("covered %0d items; ok %0d nofit %0d full %0d double %0d unknown %0d",
             result_cnt, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4]);
    if (fail_cnt == 0) begin
      $display("[segment_fit_allocator] OK");
    end else begin
      $display("[segment_fit_allocator] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
